/* hdl/raq_pkg.sv */
// ----------------------------------------------------------------------------
// raq_pkg
// Shared types and constants of the row absmax int6 quantizer.
// ----------------------------------------------------------------------------
package raq_pkg;

    localparam int MAX_ROW_LEN_DEF = 4096;

    localparam int LEN_W    = 13;   // row_length register
    localparam int WEIGHT_W = 16;
    localparam int MAG_W    = 16;   // magnitude 0..32768 fits unsigned
    localparam int CODE_W   = 6;
    localparam int QBITS    = 5;    // quotient 0..31
    localparam int DEN_W    = MAG_W + 1;          // 2 * peak
    localparam int NUM_W    = DEN_W + QBITS - 1;  // 62 * mag + peak < 2^21
    localparam int STEP_W   = $clog2(QBITS);

    localparam logic [LEN_W-1:0] ROW_LEN_RESET = LEN_W'(4096);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } raq_state_t;

    typedef struct packed {
        logic load;      // store weight, update peak and count
        logic rd;        // read weight at drain pointer
        logic start;     // set up divider, advance pointer or close the row
        logic step;      // one quotient bit
        logic out_load;  // move result into output register
    } raq_cmd_t;

    typedef struct packed {
        logic row_ready;
        logic out_free;
    } raq_sts_t;

endpackage

/* hdl/raq_if.sv */
// ----------------------------------------------------------------------------
// raq_if
// Valid/ready channels of the quantizer: item input, result output, config.
// ----------------------------------------------------------------------------
interface raq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [raq_pkg::WEIGHT_W-1:0] weight;

    modport source (output valid, output op, output weight, input ready);
    modport sink   (input valid, input op, input weight, output ready);
endinterface

interface raq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [raq_pkg::CODE_W-1:0] code;
    logic        [raq_pkg::MAG_W-1:0]  row_max;
    logic                              zero_row;
    logic                              last;

    modport source (output valid, output code, output row_max, output zero_row,
                    output last, input ready);
    modport sink   (input valid, input code, input row_max, input zero_row,
                    input last, output ready);
endinterface

interface raq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [raq_pkg::LEN_W-1:0]        data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/raq_ctrl.sv */
// ----------------------------------------------------------------------------
// raq_ctrl
// Sequencer: takes one item at a time, runs read, divide and output steps for a drain.
// ----------------------------------------------------------------------------
module raq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_op,
    output logic              item_ready,
    input  raq_pkg::raq_sts_t sts,
    output raq_pkg::raq_cmd_t cmd
);

    raq_pkg::raq_state_t              state_reg, state_next;
    logic [raq_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                             fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= raq_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign item_ready = (state_reg == raq_pkg::ST_IDLE);
    assign fire       = item_ready && item_valid;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            raq_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    if (item_op == raq_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (sts.row_ready)
                    begin
                        // drain with no finished row is taken and dropped
                        cmd.rd     = 1'b1;
                        state_next = raq_pkg::ST_READ;
                    end
                end
            end
            raq_pkg::ST_READ:
            begin
                cmd.start  = 1'b1;
                step_next  = '0;
                state_next = raq_pkg::ST_DIV;
            end
            raq_pkg::ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == raq_pkg::STEP_W'(raq_pkg::QBITS - 1))
                begin
                    state_next = raq_pkg::ST_DONE;
                end
            end
            raq_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = raq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = raq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/raq_datapath.sv */
// ----------------------------------------------------------------------------
// raq_datapath
// Weight buffer, row tracking, restoring divider and output register.
// ----------------------------------------------------------------------------
module raq_datapath
#(
    parameter int MAX_ROW_LEN = raq_pkg::MAX_ROW_LEN_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  raq_pkg::raq_cmd_t                  cmd,
    output raq_pkg::raq_sts_t                  sts,
    input  logic signed [raq_pkg::WEIGHT_W-1:0] weight,
    input  logic                               cfg_valid,
    input  logic [raq_pkg::LEN_W-1:0]          cfg_data,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [raq_pkg::CODE_W-1:0]  out_code,
    output logic [raq_pkg::MAG_W-1:0]          out_row_max,
    output logic                               out_zero_row,
    output logic                               out_last
);

    localparam int AW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
    localparam int CW = $clog2(MAX_ROW_LEN + 1);
    localparam int LW = (CW > raq_pkg::LEN_W) ? CW : raq_pkg::LEN_W;

    localparam int NUM_W = raq_pkg::NUM_W;
    localparam int MAG_W = raq_pkg::MAG_W;

    logic [raq_pkg::WEIGHT_W-1:0] mem [MAX_ROW_LEN];

    logic [raq_pkg::LEN_W-1:0]    row_len_reg;
    logic [MAG_W-1:0]             peak_reg, peak_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic                         ready_reg, ready_next;

    logic [raq_pkg::WEIGHT_W-1:0] rdata_reg;

    logic [NUM_W-1:0]             rem_reg, rem_next;
    logic [NUM_W-1:0]             dsh_reg, dsh_next;
    logic [raq_pkg::QBITS-1:0]    q_reg, q_next;
    logic                         neg_reg;
    logic                         zero_reg;
    logic                         last_reg;
    logic [MAG_W-1:0]             pk_reg;

    logic                         out_valid_reg;
    logic signed [raq_pkg::CODE_W-1:0] code_reg;
    logic [MAG_W-1:0]             rowmax_reg;
    logic                         zrow_reg;
    logic                         olast_reg;

    logic [LW-1:0]                eff_len;
    logic [CW-1:0]                base_count;
    logic [MAG_W-1:0]             base_peak;
    logic [MAG_W-1:0]             wr_mag;
    logic [MAG_W-1:0]             rd_mag;
    logic [NUM_W-1:0]             num;
    logic                         is_last;
    logic [raq_pkg::QBITS-1:0]    q_final;
    logic [raq_pkg::CODE_W-1:0]   q_ext;

    // row_length of zero acts as one, above the buffer depth as the depth
    always_comb
    begin
        if (row_len_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (LW'(row_len_reg) > LW'(MAX_ROW_LEN))
        begin
            eff_len = LW'(MAX_ROW_LEN);
        end
        else
        begin
            eff_len = LW'(row_len_reg);
        end
    end

    assign wr_mag = weight[raq_pkg::WEIGHT_W-1] ? MAG_W'(-weight) : MAG_W'(weight);
    assign rd_mag = rdata_reg[raq_pkg::WEIGHT_W-1] ? MAG_W'(-rdata_reg) : MAG_W'(rdata_reg);

    // a load into a finished or draining row starts a new one
    assign base_count = ready_reg ? '0 : count_reg;
    assign base_peak  = ready_reg ? '0 : peak_reg;
    assign is_last    = ((ptr_reg + 1'b1) == count_reg);

    // 62*mag + peak; the sum fits NUM_W bits, so the cut 64*mag term is harmless
    assign num = NUM_W'({rd_mag, 6'b0}) - NUM_W'({rd_mag, 1'b0}) + NUM_W'(peak_reg);

    always_comb
    begin
        peak_next  = peak_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        ready_next = ready_reg;
        if (cmd.load)
        begin
            peak_next  = (wr_mag > base_peak) ? wr_mag : base_peak;
            count_next = base_count + 1'b1;
            ptr_next   = ready_reg ? '0 : ptr_reg;
            ready_next = 1'b0;
            if (LW'(count_next) >= eff_len)
            begin
                ready_next = 1'b1;
                ptr_next   = '0;
            end
        end
        else if (cmd.start)
        begin
            if (is_last)
            begin
                peak_next  = '0;
                count_next = '0;
                ptr_next   = '0;
                ready_next = 1'b0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg <= raq_pkg::ROW_LEN_RESET;
            peak_reg    <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            ready_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                row_len_reg <= cfg_data;
            end
            peak_reg  <= peak_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[base_count[AW-1:0]] <= weight;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    // restoring divide of num by 2*peak, one quotient bit a cycle
    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        if (cmd.start)
        begin
            rem_next = num;
            dsh_next = NUM_W'({peak_reg, 1'b0, {(raq_pkg::QBITS-1){1'b0}}});
            q_next   = '0;
        end
        else if (cmd.step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[raq_pkg::QBITS-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[raq_pkg::QBITS-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        if (cmd.start)
        begin
            neg_reg  <= rdata_reg[raq_pkg::WEIGHT_W-1];
            zero_reg <= (peak_reg == '0);
            last_reg <= is_last;
            pk_reg   <= peak_reg;
        end
    end

    assign q_final = zero_reg ? '0 : q_reg;
    assign q_ext   = raq_pkg::CODE_W'(q_final);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            code_reg   <= neg_reg ? -$signed(q_ext) : $signed(q_ext);
            rowmax_reg <= pk_reg;
            zrow_reg   <= zero_reg;
            olast_reg  <= last_reg;
        end
    end

    assign sts.row_ready = ready_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_code     = code_reg;
    assign out_row_max  = rowmax_reg;
    assign out_zero_row = zrow_reg;
    assign out_last     = olast_reg;

endmodule

/* hdl/row_absmax_int6_quantizer_unit.sv */
// ----------------------------------------------------------------------------
// row_absmax_int6_quantizer_unit
// Per-row symmetric absmax quantizer of 16-bit weights to six-bit codes.
// ----------------------------------------------------------------------------
//  channel  dir  fields                              role
//  item     in   op, weight                          load weight / drain code
//  result   out  code, row_max, zero_row, last       one code per drain of a finished row
//  cfg      in   data                                row_length write
//
//  A drain of a finished row runs buffer read, divider setup, 5 restoring
//  divide steps and output register load.
//  The output register holds a result while the next item is accepted; a
//  stalled result only holds the next drain at its final step.
//  Reset clears the row state; the weight buffer needs no clearing.
// ----------------------------------------------------------------------------
module row_absmax_int6_quantizer_unit
#(
    parameter int MAX_ROW_LEN = raq_pkg::MAX_ROW_LEN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    raq_in_if.sink    item,
    raq_out_if.source result,
    raq_cfg_if.sink   cfg
);

    raq_pkg::raq_cmd_t cmd;
    raq_pkg::raq_sts_t sts;

    assign cfg.ready = 1'b1;

    raq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.op),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    raq_datapath
    #(
        .MAX_ROW_LEN (MAX_ROW_LEN)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .weight       (item.weight),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_code     (result.code),
        .out_row_max  (result.row_max),
        .out_zero_row (result.zero_row),
        .out_last     (result.last)
    );

endmodule
